// ----- rtl/smma_pkg.sv -----
// package for the small matrix multiply-accumulate unit
// holds sizes, widths, request/result structs and state encodings
// no dependencies
`default_nettype none

package smma_pkg;

  localparam int ROWS_A = 4;
  localparam int INNER  = 4;
  localparam int COLS_B = 4;

  localparam int SIZE_A = ROWS_A * INNER;
  localparam int SIZE_B = INNER * COLS_B;
  localparam int SIZE_C = ROWS_A * COLS_B;

  localparam int AW_A = (SIZE_A > 1) ? $clog2(SIZE_A) : 1;
  localparam int AW_B = (SIZE_B > 1) ? $clog2(SIZE_B) : 1;
  localparam int AW_C = (SIZE_C > 1) ? $clog2(SIZE_C) : 1;
  localparam int KW   = (INNER  > 1) ? $clog2(INNER)  : 1;
  localparam int RW   = (ROWS_A > 1) ? $clog2(ROWS_A) : 1;
  localparam int CW   = (COLS_B > 1) ? $clog2(COLS_B) : 1;

  localparam int ELEM_W = 16;
  localparam int CVAL_W = 48;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + 1 + $clog2(INNER);
  localparam int AX_W   = ELEM_W + ACC_W;
  localparam int BC_W   = ELEM_W + CVAL_W;
  localparam int SUM_W  = 64;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SAT_MIN = 64'shFFFF_8000_0000_0000;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic {
    REG_ALPHA = 1'b0,
    REG_BETA  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SUM
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [5:0]         elem_index;
    logic signed [15:0] elem_value;
  } item_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [47:0] out_value;
    logic               out_last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/smma_ram.sv -----
// generic single-write, single-read ram with registered read data
// used for the A, B and C element stores; no dependencies
`default_nettype none

module smma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/small_matrix_multiply_accumulate_unit.sv -----
// small matrix multiply-accumulate unit: C = alpha*A*B + beta*C
// depends on smma_pkg and smma_ram
//
// usage:
//   item channel (item_valid/item_ready/item): a request either loads one
//   element of A, B or C (column-major index, ignored when out of range) or
//   starts a compute run. loads produce no result.
//   result channel (result_valid/result_ready/result): a compute run returns
//   ROWS_A*COLS_B results in column-major order, out_last on the final one;
//   each result is also written back to the C store for chaining.
//   apb port: alpha 0x0, beta 0x4; written only while idle by user, unenforced.
// timing:
//   one shared multiply-accumulate walks A and B out of their rams, one
//   product per cycle; each C element takes INNER reads, a drain of the
//   ram/multiply/add pipe and one scale-and-saturate step; the next
//   request is taken the cycle after the last result is registered.
// reset: alpha = 1, beta = 0, no result pending; store contents are kept
//   undefined until loaded.
// stall: a held result waits in the output register; the run pauses in its
//   scale step until that register frees up.
`default_nettype none

module small_matrix_multiply_accumulate_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire smma_pkg::item_t                item,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output smma_pkg::result_t                   result,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [smma_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [smma_pkg::PDATA_W-1:0]   pwdata,
  output logic      [smma_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);

  smma_pkg::state_t state, state_next;

  logic signed [smma_pkg::ELEM_W-1:0] alpha;
  logic signed [smma_pkg::ELEM_W-1:0] beta;

  // loop counters and running addresses
  logic [smma_pkg::KW-1:0]   k;
  logic [smma_pkg::RW-1:0]   row;
  logic [smma_pkg::AW_C-1:0] pos;
  logic [smma_pkg::AW_A-1:0] a_addr;
  logic [smma_pkg::AW_B-1:0] b_addr;
  logic [smma_pkg::AW_B-1:0] b_base;

  // mac pipe
  logic                               s1_vld;
  logic                               s2_vld;
  logic signed [smma_pkg::PROD_W-1:0] prod;
  logic signed [smma_pkg::ACC_W-1:0]  acc;
  logic signed [smma_pkg::AX_W-1:0]   ax;
  logic signed [smma_pkg::BC_W-1:0]   bc;
  logic signed [smma_pkg::SUM_W-1:0]  total;
  logic signed [smma_pkg::CVAL_W-1:0] sat;

  // ram ports
  logic                               a_we, b_we, c_we;
  logic                               mac_re, c_re;
  logic [smma_pkg::AW_C-1:0]          c_waddr;
  logic [smma_pkg::CVAL_W-1:0]        c_wdata;
  logic signed [smma_pkg::ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [smma_pkg::CVAL_W-1:0] c_rdata;

  logic item_acc;
  logic start;
  logic out_load;
  logic last_k;
  logic last_row;
  logic last_elem;
  logic pipe_empty;
  logic cfg_wr;

  assign item_acc   = item_valid && item_ready;
  assign start      = item_acc && (item.opcode == smma_pkg::OP_COMPUTE);
  assign last_k     = (k == smma_pkg::KW'(smma_pkg::INNER - 1));
  assign last_row   = (row == smma_pkg::RW'(smma_pkg::ROWS_A - 1));
  assign last_elem  = (pos == smma_pkg::AW_C'(smma_pkg::SIZE_C - 1));
  assign pipe_empty = !s1_vld && !s2_vld;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      smma_pkg::ST_IDLE: begin
        if (start) begin
          state_next = smma_pkg::ST_MAC;
        end
      end
      smma_pkg::ST_MAC: begin
        if (last_k) begin
          state_next = smma_pkg::ST_DRAIN;
        end
      end
      smma_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = smma_pkg::ST_SUM;
        end
      end
      smma_pkg::ST_SUM: begin
        if (out_load) begin
          state_next = last_elem ? smma_pkg::ST_IDLE : smma_pkg::ST_MAC;
        end
      end
      default: state_next = smma_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    mac_re     = 1'b0;
    c_re       = 1'b0;
    out_load   = 1'b0;
    case (state)
      smma_pkg::ST_IDLE: item_ready = 1'b1;
      smma_pkg::ST_MAC: begin
        mac_re = 1'b1;
        c_re   = last_k;
      end
      smma_pkg::ST_DRAIN: ;
      smma_pkg::ST_SUM: out_load = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // load decode
  assign a_we = item_acc && (item.opcode == smma_pkg::OP_LOAD_A)
                && ({1'b0, item.elem_index} < 7'(smma_pkg::SIZE_A));
  assign b_we = item_acc && (item.opcode == smma_pkg::OP_LOAD_B)
                && ({1'b0, item.elem_index} < 7'(smma_pkg::SIZE_B));

  // c store is written by loads while idle and by write-back during a run;
  // the element read for scaling is never the one being written back
  always_comb begin
    if (out_load) begin
      c_we    = 1'b1;
      c_waddr = pos;
      c_wdata = sat;
    end else begin
      c_we    = item_acc && (item.opcode == smma_pkg::OP_LOAD_C)
                && ({1'b0, item.elem_index} < 7'(smma_pkg::SIZE_C));
      c_waddr = item.elem_index[smma_pkg::AW_C-1:0];
      c_wdata = {{(smma_pkg::CVAL_W - smma_pkg::ELEM_W){item.elem_value[15]}},
                 item.elem_value};
    end
  end

  smma_ram #(.WIDTH(smma_pkg::ELEM_W), .DEPTH(smma_pkg::SIZE_A)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (item.elem_index[smma_pkg::AW_A-1:0]),
    .wdata (item.elem_value),
    .re    (mac_re),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  smma_ram #(.WIDTH(smma_pkg::ELEM_W), .DEPTH(smma_pkg::SIZE_B)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (item.elem_index[smma_pkg::AW_B-1:0]),
    .wdata (item.elem_value),
    .re    (mac_re),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  smma_ram #(.WIDTH(smma_pkg::CVAL_W), .DEPTH(smma_pkg::SIZE_C)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (pos),
    .rdata (c_rdata)
  );

  // counters and addresses
  always_ff @(posedge clk) begin
    if (start) begin
      k      <= '0;
      row    <= '0;
      pos    <= '0;
      a_addr <= '0;
      b_addr <= '0;
      b_base <= '0;
    end else if (mac_re) begin
      k      <= k + smma_pkg::KW'(1);
      a_addr <= a_addr + smma_pkg::AW_A'(smma_pkg::ROWS_A);
      b_addr <= b_addr + smma_pkg::AW_B'(1);
    end else if (out_load && !last_elem) begin
      k   <= '0;
      pos <= pos + smma_pkg::AW_C'(1);
      if (last_row) begin
        row    <= '0;
        b_base <= b_base + smma_pkg::AW_B'(smma_pkg::INNER);
        b_addr <= b_base + smma_pkg::AW_B'(smma_pkg::INNER);
        a_addr <= '0;
      end else begin
        row    <= row + smma_pkg::RW'(1);
        b_addr <= b_base;
        a_addr <= smma_pkg::AW_A'(row + smma_pkg::RW'(1));
      end
    end
  end

  // mac pipe: ram read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= mac_re;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      prod <= a_rdata * b_rdata;
    end
    if (start || out_load) begin
      acc <= '0;
    end else if (s2_vld) begin
      acc <= acc + {{(smma_pkg::ACC_W - smma_pkg::PROD_W){prod[smma_pkg::PROD_W-1]}}, prod};
    end
  end

  // scale once the sum is final; old c is ignored when beta is zero
  always_ff @(posedge clk) begin
    if (state == smma_pkg::ST_DRAIN && pipe_empty) begin
      ax <= alpha * acc;
      if (beta == '0) begin
        bc <= '0;
      end else begin
        bc <= beta * c_rdata;
      end
    end
  end

  assign total = {{(smma_pkg::SUM_W - smma_pkg::AX_W){ax[smma_pkg::AX_W-1]}}, ax} + bc;

  always_comb begin
    if (total > smma_pkg::SAT_MAX) begin
      sat = smma_pkg::SAT_MAX[smma_pkg::CVAL_W-1:0];
    end else if (total < smma_pkg::SAT_MIN) begin
      sat = smma_pkg::SAT_MIN[smma_pkg::CVAL_W-1:0];
    end else begin
      sat = total[smma_pkg::CVAL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.out_index <= 6'(pos);
      result.out_value <= sat;
      result.out_last  <= last_elem;
    end
  end

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 16'sd1;
      beta  <= 16'sd0;
    end else if (cfg_wr) begin
      case (smma_pkg::reg_idx_t'(paddr[2]))
        smma_pkg::REG_ALPHA: alpha <= pwdata[smma_pkg::ELEM_W-1:0];
        smma_pkg::REG_BETA:  beta  <= pwdata[smma_pkg::ELEM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (smma_pkg::reg_idx_t'(paddr[2]))
      smma_pkg::REG_ALPHA:
        prdata = {{(smma_pkg::PDATA_W - smma_pkg::ELEM_W){alpha[15]}}, alpha};
      smma_pkg::REG_BETA:
        prdata = {{(smma_pkg::PDATA_W - smma_pkg::ELEM_W){beta[15]}}, beta};
      default: prdata = '0;
    endcase
  end

  // checks
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> $past(s1_vld))
    else $error("accumulate stage without a preceding multiply");

  a_start_mac: assert property (@(posedge clk) disable iff (rst)
    start |=> state == smma_pkg::ST_MAC)
    else $error("compute request did not start the mac loop");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_elem) |=> (state == smma_pkg::ST_IDLE && result.out_last))
    else $error("run did not end on the last element");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == smma_pkg::ST_SUM)
    else $error("result raised outside the scale step");

endmodule

`default_nettype wire

// ----- sim/small_matrix_multiply_accumulate_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for small_matrix_multiply_accumulate_unit (C = alpha*A*B + beta*C)
// predicts every C result in a scoreboard class; drives requests, apb writes and result stalls
// depends on smma_pkg and the unit rtl only

module small_matrix_multiply_accumulate_unit_tb;
  import smma_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 150;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 26;
  localparam int MAX_REPORTS   = 40;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  class gemm_scoreboard;
    logic signed [ELEM_W-1:0] a_elems [SIZE_A];
    logic signed [ELEM_W-1:0] b_elems [SIZE_B];
    logic signed [CVAL_W-1:0] c_elems [SIZE_C];
    longint  alpha_q;
    longint  beta_q;
    result_t c_expected [$];
    int loads, ignored, computes, saturated, checked, mismatches;

    function new();
      alpha_q = 1;
      beta_q  = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic signed [ELEM_W-1:0] v);
      if (r == REG_ALPHA) alpha_q = longint'(v);
      else beta_q = longint'(v);
    endfunction

    function int pending();
      return c_expected.size();
    endfunction

    // applies one accepted request; a compute queues the whole new C
    function void take_request(item_t req);
      longint  dot;
      longint  acc;
      int      pos;
      result_t want;
      if (req.opcode != OP_COMPUTE) loads++;
      case (req.opcode)
        OP_LOAD_A: if (req.elem_index < SIZE_A) a_elems[req.elem_index] = req.elem_value;
                   else ignored++;
        OP_LOAD_B: if (req.elem_index < SIZE_B) b_elems[req.elem_index] = req.elem_value;
                   else ignored++;
        OP_LOAD_C: if (req.elem_index < SIZE_C) c_elems[req.elem_index] = CVAL_W'(req.elem_value);
                   else ignored++;
        default: begin
          computes++;
          for (int j = 0; j < COLS_B; j++) begin
            for (int i = 0; i < ROWS_A; i++) begin
              pos = i + j * ROWS_A;
              dot = 0;
              for (int k = 0; k < INNER; k++)
                dot += longint'(a_elems[i + k * ROWS_A]) * longint'(b_elems[k + j * INNER]);
              acc = alpha_q * dot;
              // beta of zero drops old C entirely
              if (beta_q != 0) acc += beta_q * longint'(c_elems[pos]);
              if (acc > SAT_MAX) begin
                acc = SAT_MAX;
                saturated++;
              end else if (acc < SAT_MIN) begin
                acc = SAT_MIN;
                saturated++;
              end
              c_elems[pos]    = acc[CVAL_W-1:0];
              want.out_index  = pos[5:0];
              want.out_value  = acc[CVAL_W-1:0];
              want.out_last   = (pos == SIZE_C - 1);
              c_expected.push_back(want);
            end
          end
        end
      endcase
    endfunction

    function void note_fail(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (c_expected.size() == 0) begin
        note_fail("result with nothing due, out_index", -1, got.out_index);
        return;
      end
      want = c_expected.pop_front();
      checked++;
      if (got.out_index !== want.out_index)
        note_fail("out_index", want.out_index, got.out_index);
      if (got.out_value !== want.out_value)
        note_fail("out_value", longint'(want.out_value), longint'(got.out_value));
      if (got.out_last !== want.out_last)
        note_fail("out_last", want.out_last, got.out_last);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  item_t               item_req;
  logic                result_valid;
  logic                result_ready;
  result_t             result_out;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  gemm_scoreboard board = new();
  int       cycles      = 0;
  int       burst_left  = 0;
  int       sent        = 0;
  int       scale_sets  = 0;
  rx_mode_t rx_mode     = RX_FREE;
  int       rx_left     = 0;

  small_matrix_multiply_accumulate_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_req),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still due", $time, board.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stalls on its own pattern of stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(1, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:   result_ready <= 1'b1;
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 7) == 0);
      default:   result_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_result(result_out);
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'sh0001;
      4:       return -16'sh0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t random_request();
    item_t req;
    int    pick;
    int    depth;
    pick = $urandom_range(0, 99);
    req.opcode     = (pick < 12) ? OP_COMPUTE : op_t'($urandom_range(0, 2));
    depth          = (req.opcode == OP_LOAD_A) ? SIZE_A :
                     (req.opcode == OP_LOAD_B) ? SIZE_B : SIZE_C;
    req.elem_value = pick_value();
    if (req.opcode == OP_COMPUTE) req.elem_index = 6'($urandom);
    else if (pick < 20) req.elem_index = 6'($urandom_range(depth, 63));
    else req.elem_index = 6'($urandom_range(0, depth - 1));
    return req;
  endfunction

  // sender bursts with random gaps, now and then drains all results first
  task automatic pace(input bit gap_free);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gap_free ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) begin
        item_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        @(posedge clk);
      end else if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input item_t req);
    item_valid <= 1'b1;
    item_req   <= req;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    board.take_request(req);
    sent++;
  endtask

  task automatic send_op(input op_t op, input int idx, input logic signed [15:0] v);
    item_t req;
    req.opcode     = op;
    req.elem_index = 6'(idx);
    req.elem_value = v;
    pace(1'b0);
    send_item(req);
  endtask

  task automatic fill_store(input op_t op, input logic signed [15:0] v);
    int depth;
    depth = (op == OP_LOAD_A) ? SIZE_A : (op == OP_LOAD_B) ? SIZE_B : SIZE_C;
    for (int n = 0; n < depth; n++) send_op(op, n, v);
  endtask

  // registers only change once every due result is out and the unit is idle
  task automatic settle_idle();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_scales(input logic signed [15:0] alpha_v,
                                input logic signed [15:0] beta_v);
    reg_idx_t           r;
    logic signed [15:0] v;
    psel   <= 1'b1;
    pwrite <= 1'b1;
    for (int n = 0; n < 2; n++) begin
      r = (n == 0) ? REG_ALPHA : REG_BETA;
      v = (n == 0) ? alpha_v : beta_v;
      penable <= 1'b0;
      paddr   <= PADDR_W'(4 * int'(r));
      pwdata  <= PDATA_W'(v);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      board.set_reg(r, v);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scale_sets++;
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item_req     = '0;
    result_ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // extremes everywhere; first compute runs on the reset scales
    fill_store(OP_LOAD_A, 16'sh8000);
    fill_store(OP_LOAD_B, 16'sh8000);
    fill_store(OP_LOAD_C, 16'sh7FFF);
    send_op(OP_LOAD_A, SIZE_A, 16'sh7FFF);
    send_op(OP_LOAD_B, 63, 16'sh1234);
    send_op(OP_LOAD_C, 47, -16'sh0001);
    send_op(OP_COMPUTE, 0, 16'sh0000);

    // pushes past the positive limit, then the negative one
    settle_idle();
    program_scales(16'sh7FFF, 16'sh7FFF);
    send_op(OP_COMPUTE, 63, 16'sh7FFF);
    settle_idle();
    program_scales(16'sh8000, 16'sh8000);
    send_op(OP_COMPUTE, 21, -16'sh0001);

    // negating the most negative C saturates high
    settle_idle();
    program_scales(16'sh0000, -16'sh0001);
    send_op(OP_COMPUTE, 42, 16'sh5555);

    settle_idle();
    program_scales(16'sh0001, 16'sh0001);
    send_op(OP_LOAD_A, 0, 16'sh7FFF);
    send_op(OP_LOAD_C, SIZE_C - 1, 16'sh8000);
    send_op(OP_COMPUTE, 0, 16'sh0000);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      bit gap_free;
      settle_idle();
      program_scales(pick_value(), pick_value());
      gap_free = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pace(gap_free);
        send_item(random_request());
      end
    end

    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d loads (%0d out of range), %0d computes",
             sent, board.loads, board.ignored, board.computes);
    $display("checked %0d results under %0d scale settings, %0d of them saturated",
             board.checked, scale_sets, board.saturated);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/smma_pkg.sv
rtl/smma_ram.sv
rtl/small_matrix_multiply_accumulate_unit.sv
sim/small_matrix_multiply_accumulate_unit_tb.sv
